[src/sfr_pkg.sv]
// shared constants and crc helper for the sync crc frame receiver
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;
	localparam int BufBytes = 64;
	localparam int AddrW = $clog2(BufBytes);
	localparam int FillW = AddrW + 1;
	localparam logic [7:0] SyncA = 8'h55;
	localparam logic [7:0] SyncB = 8'hAA;
	localparam logic [15:0] CrcPoly = 16'hA001;
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [FillW-1:0] MinHold = FillW'(10);
	localparam logic [15:0] MaxPayload = 16'd54;
	localparam logic [AddrW-1:0] HdrBytes = AddrW'(8);

	// one byte through the reflected crc-16, bit by bit
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction
endpackage
`default_nettype wire

[src/sfr_buf.sv]
// byte store ram, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module sfr_buf
	import sfr_pkg::*;
(
	input wire logic clk,
	input wire logic we,
	input wire logic [AddrW-1:0] waddr,
	input wire logic [7:0] wdata,
	input wire logic [AddrW-1:0] raddr,
	output logic [7:0] rdata
);
	logic [7:0] mem [BufBytes];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[src/sync_crc_frame_receiver_core.sv]
// top level: byte deframer with sync search, header check and crc-16
`timescale 1ns / 1ps
`default_nettype none
// Takes one received byte per transfer into a 64-byte circular store and then
// parses: sync search for 0x55 0xAA, version and length check, CRC-16 (0xA001
// reflected, init 0xFFFF) over bytes 2..7 and the payload, then one result per
// payload byte (one for an empty frame). All parsing runs on a single read port
// of the store with a registered read, and s_tready is low meanwhile. A byte
// that leaves fewer than ten bytes held sends the parser straight back to idle.
// Otherwise each parse pass scans bytes up to the sync pair, reads the header,
// runs the crc, reads the two check bytes and then emits the results;
// a rejected header drops one byte and repeats the pass, and a waiting result
// stalls the parser until it is taken.
module sync_crc_frame_receiver_core
	import sfr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata, // [7:0] rx_byte
	output logic m_tvalid,
	input wire logic m_tready,
	// [7:0] message_type, [15:8] command_id, [23:16] sequence_res,
	// [29:24] payload_length, [37:30] payload_byte, [39:38] zero
	output logic [39:0] m_tdata,
	output logic [0:0] m_tuser, // [0] byte_present
	output logic m_tlast,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [7:0] cfg_data
);
	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_USE, S_HDR_RD, S_HDR_USE,
		S_CRC_RD, S_CRC_USE, S_RC_RD, S_RC_USE, S_EMIT_RD, S_EMIT_USE
	} state_t;

	state_t state_q;
	logic [AddrW-1:0] head_q;
	logic [FillW-1:0] fill_q;
	logic [FillW-1:0] off_q;
	logic [7:0] prev_q;
	logic [7:0] version_q;
	logic [7:0] mtype_q, cmd_q, seq_q, plo_q, phi_q;
	logic [15:0] crc_q;
	logic [7:0] rclo_q;
	logic [39:0] out_data_q;
	logic out_user_q, out_last_q, out_valid_q;
	logic [7:0] rdata;
	logic [AddrW-1:0] raddr;
	logic in_xfer;
	logic [FillW-1:0] plen7, flen7;
	logic [15:0] plen16;

	assign in_xfer = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign raddr = head_q + off_q[AddrW-1:0];
	assign plen16 = {phi_q, plo_q};
	assign plen7 = plo_q[FillW-1:0];
	assign flen7 = plen7 + FillW'(10);

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;
	assign m_tlast = out_last_q;

	sfr_buf u_buf (
		.clk(clk),
		.we(in_xfer && (fill_q < FillW'(BufBytes))),
		.waddr(head_q + fill_q[AddrW-1:0]),
		.wdata(s_tdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			version_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			fill_q <= '0;
			off_q <= '0;
			prev_q <= '0;
			mtype_q <= '0;
			cmd_q <= '0;
			seq_q <= '0;
			plo_q <= '0;
			phi_q <= '0;
			crc_q <= '0;
			rclo_q <= '0;
			out_data_q <= '0;
			out_user_q <= 1'b0;
			out_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						// a full store is flushed and the new byte dropped
						fill_q <= (fill_q < FillW'(BufBytes)) ? fill_q + 1'b1 : '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					off_q <= '0;
					state_q <= (fill_q < MinHold) ? S_IDLE : S_SCAN_RD;
				end
				S_SCAN_RD: state_q <= S_SCAN_USE;
				S_SCAN_USE: begin
					prev_q <= rdata;
					if (off_q != '0 && prev_q == SyncA && rdata == SyncB) begin
						head_q <= head_q + AddrW'(off_q - 1'b1);
						fill_q <= fill_q - (off_q - 1'b1);
						off_q <= FillW'(2);
						state_q <= ((fill_q - (off_q - 1'b1)) < MinHold) ? S_IDLE : S_HDR_RD;
					end else if (off_q == fill_q - 1'b1) begin
						fill_q <= '0;
						state_q <= S_IDLE;
					end else begin
						off_q <= off_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_HDR_RD: state_q <= S_HDR_USE;
				S_HDR_USE: begin
					off_q <= off_q + 1'b1;
					state_q <= S_HDR_RD;
					case (off_q[2:0])
						3'd2: begin
							if (rdata != version_q) begin
								head_q <= head_q + 1'b1;
								fill_q <= fill_q - 1'b1;
								state_q <= S_CHECK;
							end
						end
						3'd3: mtype_q <= rdata;
						3'd4: cmd_q <= rdata;
						3'd5: seq_q <= rdata;
						3'd6: plo_q <= rdata;
						default: begin
							phi_q <= rdata;
							if ({rdata, plo_q} > MaxPayload) begin
								head_q <= head_q + 1'b1;
								fill_q <= fill_q - 1'b1;
								state_q <= S_CHECK;
							end else if (fill_q < plo_q[FillW-1:0] + FillW'(10)) begin
								state_q <= S_IDLE;
							end else begin
								crc_q <= CrcInit;
								off_q <= FillW'(2);
								state_q <= S_CRC_RD;
							end
						end
					endcase
				end
				S_CRC_RD: state_q <= S_CRC_USE;
				S_CRC_USE: begin
					crc_q <= crc_byte(crc_q, rdata);
					off_q <= off_q + 1'b1;
					state_q <= (off_q == plen7 + FillW'(7)) ? S_RC_RD : S_CRC_RD;
				end
				S_RC_RD: state_q <= S_RC_USE;
				S_RC_USE: begin
					if (off_q == flen7 - FillW'(2)) begin
						rclo_q <= rdata;
						off_q <= off_q + 1'b1;
						state_q <= S_RC_RD;
					end else if ({rdata, rclo_q} == crc_q) begin
						off_q <= FillW'(HdrBytes);
						state_q <= S_EMIT_RD;
					end else begin
						head_q <= head_q + flen7[AddrW-1:0];
						fill_q <= fill_q - flen7;
						state_q <= S_CHECK;
					end
				end
				S_EMIT_RD: state_q <= S_EMIT_USE;
				S_EMIT_USE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_user_q <= (plen16 != 16'd0);
						out_data_q <= {2'b00, (plen16 != 16'd0) ? rdata : 8'h00,
							plo_q[5:0], seq_q, cmd_q, mtype_q};
						// last item: empty frame or final payload byte
						if (plen16 == 16'd0 || off_q == plen7 + FillW'(7)) begin
							out_last_q <= 1'b1;
							head_q <= head_q + flen7[AddrW-1:0];
							fill_q <= fill_q - flen7;
							state_q <= S_CHECK;
						end else begin
							out_last_q <= 1'b0;
							off_q <= off_q + 1'b1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[src/sfr_checker.sv]
// port-level checks for the frame receiver, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module sfr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [0:0] m_tuser,
	input wire logic m_tlast
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// empty frame gives one zero item marked last
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[37:30] == 8'h00 && m_tdata[29:24] == 6'd0 && m_tlast)
		else $error("bad empty frame item");

	a_len_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[29:24] != 6'd0)
		else $error("payload byte with zero length");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[29:24] <= 6'd54 && m_tdata[39:38] == 2'b00)
		else $error("payload length out of range");
endmodule

bind sync_crc_frame_receiver_core sfr_checker u_sfr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser),
	.m_tlast(m_tlast)
);
`default_nettype wire

[sim/tb.sv]
// testbench for the sync crc frame receiver: frame stimulus, predicted results, checks
`timescale 1ns / 1ps
module tb;
	import sfr_pkg::*;

	typedef struct packed {
		logic [7:0] mtype;
		logic [7:0] cmd_id;
		logic [7:0] seq_no;
		logic [5:0] pay_len;
		logic [7:0] pay_byte;
		logic present;
		logic last;
	} frame_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = 8'h00;

	sync_crc_frame_receiver_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [7:0] rx_pending[$];
	frame_res_t frames_due[$];
	logic [7:0] shadow_store[64];
	int shadow_fill;
	logic [7:0] shadow_version;
	int errors = 0;
	int send_idle_pct = 13;
	int recv_idle_pct = 87;
	int hold_cycles = 0;
	logic stall_rx = 1'b0;
	longint cycle_count = 0;
	int bytes_sent = 0;

	// payload crc over shadow store offsets
	function automatic logic [15:0] shadow_crc(int first, int count);
		logic [15:0] c;
		c = 16'hFFFF;
		for (int i = 0; i < count; i++) begin
			c ^= {8'h00, shadow_store[first + i]};
			for (int b = 0; b < 8; b++)
				c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	function automatic void shadow_drop(int n);
		if (n >= shadow_fill) begin
			shadow_fill = 0;
			return;
		end
		for (int i = 0; i < shadow_fill - n; i++)
			shadow_store[i] = shadow_store[i + n];
		shadow_fill -= n;
	endfunction

	function automatic void predict_byte(logic [7:0] rx);
		int start, plen, flen, items;
		frame_res_t r;
		if (shadow_fill < 64) begin
			shadow_store[shadow_fill] = rx;
			shadow_fill++;
		end else
			shadow_fill = 0;
		while (shadow_fill >= 10) begin
			start = 0;
			while (start + 1 < shadow_fill &&
				!(shadow_store[start] == 8'h55 && shadow_store[start + 1] == 8'hAA))
				start++;
			if (start + 1 >= shadow_fill) begin
				shadow_fill = 0;
				break;
			end
			shadow_drop(start);
			if (shadow_fill < 10)
				break;
			if (shadow_store[2] != shadow_version) begin
				shadow_drop(1);
				continue;
			end
			plen = {shadow_store[7], shadow_store[6]};
			flen = 10 + plen;
			if (plen > 54 || flen > 64) begin
				shadow_drop(1);
				continue;
			end
			if (shadow_fill < flen)
				break;
			if ({shadow_store[flen - 1], shadow_store[flen - 2]} == shadow_crc(2, 6 + plen)) begin
				items = plen ? plen : 1;
				for (int k = 0; k < items; k++) begin
					r.mtype = shadow_store[3];
					r.cmd_id = shadow_store[4];
					r.seq_no = shadow_store[5];
					r.pay_len = plen[5:0];
					r.pay_byte = plen ? shadow_store[8 + k] : 8'h00;
					r.present = plen != 0;
					r.last = (k + 1 == items);
					frames_due.push_back(r);
				end
			end
			shadow_drop(flen);
		end
	endfunction

	// builds one frame; flaws: 1 bad crc, 2 bad version, 3 oversize length
	task automatic queue_frame(int plen, int flaw);
		logic [7:0] f[$];
		logic [15:0] c;
		f = '{8'h55, 8'hAA, shadow_version, 8'($urandom), 8'($urandom), 8'($urandom),
			8'(plen), 8'(plen >> 8)};
		if (flaw == 2)
			f[2] = shadow_version ^ 8'(1 << $urandom_range(0, 7));
		if (flaw == 3) begin
			f[6] = 8'($urandom_range(55, 255));
			f[7] = 8'($urandom);
		end
		for (int i = 0; i < plen; i++)
			f.push_back(8'($urandom));
		c = 16'hFFFF;
		for (int i = 2; i < f.size(); i++)
			c = crc_byte(c, f[i]);
		if (flaw == 1)
			c ^= 16'(1 << $urandom_range(0, 15));
		f.push_back(c[7:0]);
		f.push_back(c[15:8]);
		foreach (f[i])
			rx_pending.push_back(f[i]);
	endtask

	task automatic drain_and_wait();
		while (rx_pending.size() != 0 || s_tvalid || frames_due.size() != 0)
			@(posedge clk);
		// a trailing byte may still be parsing
		repeat (3) @(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_version(logic [7:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_version = v;
	endtask

	task automatic random_phase(int n);
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			if (kind < 6)
				queue_frame($urandom_range(0, 3) == 0 ? $urandom_range(0, 54)
					: $urandom_range(0, 8), 0);
			else if (kind < 9)
				queue_frame($urandom_range(0, 6), kind - 5);
			else
				repeat ($urandom_range(1, 12)) rx_pending.push_back(8'($urandom));
		end
	endtask

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_byte(s_tdata);
				bytes_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tdata <= rx_pending.pop_front();
					s_tvalid <= 1'b1;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted down here
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			stall_rx <= 1'b1;
		end else
			stall_rx <= 1'b0;
	end

	// receiver and checker
	always @(posedge clk) begin
		frame_res_t exp_r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (frames_due.size() == 0) begin
					$error("unexpected result transfer %h", m_tdata);
					errors++;
				end else begin
					exp_r = frames_due.pop_front();
					if (m_tdata[7:0] !== exp_r.mtype) begin
						$error("message_type exp %h got %h", exp_r.mtype, m_tdata[7:0]);
						errors++;
					end
					if (m_tdata[15:8] !== exp_r.cmd_id) begin
						$error("command_id exp %h got %h", exp_r.cmd_id, m_tdata[15:8]);
						errors++;
					end
					if (m_tdata[23:16] !== exp_r.seq_no) begin
						$error("sequence_res exp %h got %h", exp_r.seq_no, m_tdata[23:16]);
						errors++;
					end
					if (m_tdata[29:24] !== exp_r.pay_len) begin
						$error("payload_length exp %0d got %0d", exp_r.pay_len,
							m_tdata[29:24]);
						errors++;
					end
					if (m_tdata[37:30] !== exp_r.pay_byte) begin
						$error("payload_byte exp %h got %h", exp_r.pay_byte, m_tdata[37:30]);
						errors++;
					end
					if (m_tuser[0] !== exp_r.present) begin
						$error("byte_present exp %b got %b", exp_r.present, m_tuser[0]);
						errors++;
					end
					if (m_tlast !== exp_r.last) begin
						$error("last_of_frame exp %b got %b", exp_r.last, m_tlast);
						errors++;
					end
				end
			end
			if (stall_rx)
				m_tready <= 1'b0;
			else
				m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 3000000) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		shadow_fill = 0;
		shadow_version = 8'd1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty frame, full payload, each reject path, sync hunting
		queue_frame(0, 0);
		queue_frame(54, 0);
		queue_frame(1, 1);
		queue_frame(2, 2);
		queue_frame(0, 3);
		repeat (3) rx_pending.push_back(8'h55);
		queue_frame(3, 0);
		repeat (12) rx_pending.push_back(8'h00);
		drain_and_wait();
		// version 0: a header with an oversize length, 56 random bytes, then a frame
		write_version(8'h00);
		rx_pending.push_back(8'h55);
		rx_pending.push_back(8'hAA);
		rx_pending.push_back(8'h00);
		repeat (5) rx_pending.push_back(8'hFF);
		rx_pending.push_back(8'd54);
		rx_pending.push_back(8'd0);
		repeat (56) rx_pending.push_back(8'($urandom));
		queue_frame(4, 0);
		drain_and_wait();
		write_version(8'hFF);
		random_phase(2);
		drain_and_wait();
		write_version(8'd1);
		// long receiver stall while bytes keep coming
		hold_cycles = 4000;
		random_phase(6);
		drain_and_wait();
		send_idle_pct = 87;
		recv_idle_pct = 13;
		write_version(8'($urandom));
		random_phase(4);
		drain_and_wait();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_version(8'h7E);
		random_phase(4);
		drain_and_wait();
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule

[files.f]
src/sfr_pkg.sv
src/sfr_buf.sv
src/sync_crc_frame_receiver_core.sv
src/sfr_checker.sv
sim/tb.sv
